>>> rtl/batpc_pkg.sv
// Shared constants, widths and control types of the block averager with calibration.
package batpc_pkg;

    localparam int BLOCK_LEN  = 20;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = $clog2(BLOCK_LEN * 4095 + 1);
    localparam int CNT_W      = $clog2(BLOCK_LEN + 1);

    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MID  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAL  = 2'd3;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] MID_SCALE  = 12'd2048;
    localparam logic [SAMPLE_W-1:0] LOW_RESET  = 12'd0;

    // mean by reciprocal: exact while sum * (recip * BLOCK_LEN - 2^shift) < 2^shift
    localparam int MEAN_SHIFT   = 24;
    localparam int MEAN_RECIP_I = (2 ** MEAN_SHIFT + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int RECIP_W      = $clog2(MEAN_RECIP_I + 1);
    localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(MEAN_RECIP_I);
    localparam int PROD_W       = SUM_W + RECIP_W;

    // divider: dividend below divisor * 2^12, so 12 quotient bits
    localparam int NUM_W      = 23;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic in_ready;
        logic mean_start;
        logic mean_take;
        logic map_eval;
        logic map_take;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic block_end;
        logic last;
        logic div_done;
        logic map_div;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/batpc_div.sv
// Restoring divider, one quotient bit per cycle, 12-bit quotient.
module batpc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [batpc_pkg::NUM_W-1:0]     num,
    input  logic [batpc_pkg::SAMPLE_W-1:0]  den,
    output logic                            done,
    output logic [batpc_pkg::SAMPLE_W-1:0]  quot
);
    import batpc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [SAMPLE_W-1:0]  quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  den_reg, den_next;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = SAMPLE_W'(num[NUM_W-1:SAMPLE_W]);
            quo_next  = num[SAMPLE_W-1:0];
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[SAMPLE_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> rtl/batpc_dp.sv
// Datapath: sample accumulator, calibration registers, mapping arithmetic, output register.
module batpc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [batpc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [batpc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [batpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [batpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  batpc_pkg::ctrl_cmd_t              cmd,
    output batpc_pkg::dp_stat_t               stat
);
    import batpc_pkg::*;

    logic [SAMPLE_W-1:0] low_reg, low_next;
    logic [SAMPLE_W-1:0] mid_reg, mid_next;
    logic [SAMPLE_W-1:0] high_reg, high_next;
    logic                cal_reg, cal_next;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_add;
    logic                accept;
    logic                last;

    logic [SUM_W-1:0]    total_reg, total_next;
    logic [PROD_W-1:0]   mean_prod;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [SAMPLE_W-1:0] mapped_reg, mapped_next;
    logic                upper_reg, upper_next;
    logic                mval_reg, mval_next;
    logic [SAMPLE_W-1:0] out_mean_reg, out_mean_next;
    logic [SAMPLE_W-1:0] out_map_reg, out_map_next;

    logic                map_div;
    logic                lower;
    logic [SAMPLE_W-1:0] d_lo;
    logic [SAMPLE_W-1:0] d_hi;
    logic [NUM_W-1:0]    num_lo;
    logic [NUM_W-1:0]    num_hi;
    logic [SAMPLE_W-1:0] direct;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [SAMPLE_W-1:0] div_den;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;

    // configuration
    always_comb begin
        low_next  = low_reg;
        mid_next  = mid_reg;
        high_next = high_reg;
        cal_next  = cal_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LOW:  low_next  = cfg_wdata[SAMPLE_W-1:0];
                CFG_MID:  mid_next  = cfg_wdata[SAMPLE_W-1:0];
                CFG_HIGH: high_next = cfg_wdata[SAMPLE_W-1:0];
                CFG_CAL:  cal_next  = cfg_wdata[0];
                default:  ;
            endcase
        end
    end

    // accumulate
    assign accept  = s_tvalid && cmd.in_ready;
    assign last    = cnt_reg == CNT_W'(BLOCK_LEN - 1);
    assign sum_add = sum_reg + SUM_W'(s_tdata[SAMPLE_W-1:0]);

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            if (last) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    assign mean_prod = PROD_W'(total_reg) * PROD_W'(MEAN_RECIP);

    // mapping
    assign lower   = mean_reg < mid_reg;
    assign map_div = cal_reg && (mean_reg > low_reg) && (mean_reg < high_reg)
                     && (mean_reg != mid_reg);
    assign d_lo    = mean_reg - low_reg;
    assign d_hi    = mean_reg - mid_reg;
    assign num_lo  = {d_lo, 11'd0};
    assign num_hi  = {d_hi, 11'd0} - NUM_W'(d_hi);

    always_comb begin
        priority if (!cal_reg) begin
            direct = mean_reg;
        end else if (mean_reg <= low_reg) begin
            direct = LOW_RESET;
        end else if (mean_reg >= high_reg) begin
            direct = FULL_SCALE;
        end else begin
            direct = MID_SCALE;
        end
    end

    assign div_start = cmd.map_eval && map_div;

    always_comb begin
        if (lower) begin
            div_num = num_lo;
            div_den = mid_reg - low_reg;
        end else begin
            div_num = num_hi;
            div_den = high_reg - mid_reg;
        end
    end

    batpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        total_next    = total_reg;
        mean_next     = mean_reg;
        mapped_next   = mapped_reg;
        upper_next    = upper_reg;
        mval_next     = mval_reg;
        out_mean_next = out_mean_reg;
        out_map_next  = out_map_reg;
        if (cmd.mean_start) begin
            total_next = sum_add;
        end
        if (cmd.mean_take) begin
            mean_next = mean_prod[MEAN_SHIFT +: SAMPLE_W];
        end
        if (cmd.map_eval) begin
            mapped_next = direct;
            upper_next  = !lower;
        end
        if (cmd.map_take) begin
            mapped_next = upper_reg ? (MID_SCALE + div_quot) : div_quot;
        end
        if (m_tready) begin
            mval_next = 1'b0;
        end
        if (cmd.out_load) begin
            mval_next     = 1'b1;
            out_mean_next = mean_reg;
            out_map_next  = mapped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_RESET;
            mid_reg  <= MID_SCALE;
            high_reg <= FULL_SCALE;
            cal_reg  <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            mval_reg <= 1'b0;
        end else begin
            low_reg  <= low_next;
            mid_reg  <= mid_next;
            high_reg <= high_next;
            cal_reg  <= cal_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            mval_reg <= mval_next;
        end
        total_reg    <= total_next;
        mean_reg     <= mean_next;
        mapped_reg   <= mapped_next;
        upper_reg    <= upper_next;
        out_mean_reg <= out_mean_next;
        out_map_reg  <= out_map_next;
    end

    assign s_tready = cmd.in_ready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = M_TDATA_W'({out_map_reg, out_mean_reg});

    assign stat.block_end = s_tvalid && last;
    assign stat.last      = last;
    assign stat.div_done  = div_done;
    assign stat.map_div   = map_div;
    assign stat.out_free  = !mval_reg || m_tready;

endmodule

>>> rtl/batpc_ctrl.sv
// Controller: sequences mean scaling, mapping and result hand-off.
module batpc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  batpc_pkg::dp_stat_t    stat,
    output batpc_pkg::ctrl_cmd_t   cmd
);
    import batpc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MEAN    = 3'd1;
    localparam logic [2:0] S_MAP     = 3'd2;
    localparam logic [2:0] S_MAP_DIV = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.in_ready   = (state_reg == S_IDLE) || !stat.last;
        unique case (state_reg)
            S_IDLE: begin
                if (stat.block_end) begin
                    cmd.mean_start = 1'b1;
                    state_next     = S_MEAN;
                end
            end
            S_MEAN: begin
                cmd.mean_take = 1'b1;
                state_next    = S_MAP;
            end
            S_MAP: begin
                cmd.map_eval = 1'b1;
                state_next   = stat.map_div ? S_MAP_DIV : S_OUT;
            end
            S_MAP_DIV: begin
                if (stat.div_done) begin
                    cmd.map_take = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/block_average_three_point_calibrate_core.sv
// Top level: block averager with three-point calibration.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[11:0] sample
//  m_        out  m_tvalid/m_tready    m_tdata[11:0] block_mean, [23:12] mapped_value
//  cfg_      in   cfg_wr_en            cfg_addr index, cfg_wdata value
//
// Samples are taken one per cycle. The sample that closes a block latches the block sum;
// the mean follows in the next cycle by reciprocal multiplication, and an interpolation
// runs on a 12-step divider before the word is loaded to m_; without interpolation the
// mapped value is registered directly. Other samples keep flowing meanwhile; only the next
// block-closing sample waits for that work to hand off. A stalled m_ side holds the
// hand-off stage.
// Reset is synchronous with aresetn low; no clearing pass.
module block_average_three_point_calibrate_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [batpc_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [batpc_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] block_mean, [23:12] mapped_value
    input  logic                              cfg_wr_en,
    input  logic [batpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [batpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import batpc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    batpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    batpc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> rtl/batpc_chk.sv
// Port-level checker for the block averager, bound to the top level.
module batpc_chk (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [batpc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [batpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [batpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import batpc_pkg::*;

    logic                cal_reg, cal_next;
    logic [SAMPLE_W-1:0] low_reg, low_next;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] mapped;

    assign mean   = m_tdata[SAMPLE_W-1:0];
    assign mapped = m_tdata[2*SAMPLE_W-1:SAMPLE_W];

    // track calibration flag and low point
    always_comb begin
        cal_next = cal_reg;
        low_next = low_reg;
        if (cfg_wr_en && (cfg_addr == CFG_CAL)) begin
            cal_next = cfg_wdata[0];
        end
        if (cfg_wr_en && (cfg_addr == CFG_LOW)) begin
            low_next = cfg_wdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= 1'b0;
            low_reg <= LOW_RESET;
        end else begin
            cal_reg <= cal_next;
            low_reg <= low_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !cal_reg |-> mapped == mean)
        else $error("mapped value differs from mean with calibration off");

    a_low_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cal_reg && (mean <= low_reg) |-> mapped == LOW_RESET)
        else $error("mean at or below low point not mapped to zero");

endmodule

bind block_average_three_point_calibrate_core batpc_chk u_batpc_chk (.*);
